// File: rtl/core/kslpc_pkg.sv
// types and codes for the key short/long press classifier
// no dependencies; imported by key_short_long_press_classifier
`default_nettype none

package kslpc_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned DebW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned EvW    = 2;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_CONFIRM = 5'b00010,
    PH_HELD    = 5'b00100,
    PH_SHORT   = 5'b01000,
    PH_LONG    = 5'b10000
  } phase_e;

  typedef enum logic [EvW-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_LEVEL   = 2'd0,
    REG_DEBOUNCE_TICKS = 2'd1,
    REG_LONG_TICKS     = 2'd2
  } reg_idx_e;

  localparam logic            ActiveLevelRst   = 1'b0;
  localparam logic [DebW-1:0] DebounceTicksRst = 8'd3;
  localparam logic [CntW-1:0] LongTicksRst     = 16'd200;

endpackage

`default_nettype wire

// File: rtl/core/key_short_long_press_classifier.sv
// key short/long press classifier: debounce filter and press classifier
// depends on kslpc_pkg for phase, event and register index codes
//
// each accepted pin sample gives its press_event word in the output register in the next cycle
// throughput: one sample per cycle while the output register is empty or being drained;
// the phase/counter update is combinational logic, registered as each sample is accepted
// reset: phase idle, counter zero, output empty, registers active_level 0,
// debounce_ticks 3, long_ticks 200
`default_nettype none

module key_short_long_press_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [0] pin_level
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,  // [1:0] press_event
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kslpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [kslpc_pkg::CfgW-1:0]    cfg_data_i
);
  import kslpc_pkg::*;

  logic            active_level_q;
  logic [DebW-1:0] debounce_ticks_q;
  logic [CntW-1:0] long_ticks_q;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_inc;
  event_e          ev_d;
  event_e          ev_q;
  logic            out_valid_q;
  logic            in_acc;
  logic            pressed;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(8 - EvW){1'b0}}, ev_q};

  assign pressed = (s_axis_tdata_i[0] == active_level_q);
  // saturating increment
  assign cnt_inc = (cnt_q == {CntW{1'b1}}) ? cnt_q : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q   <= ActiveLevelRst;
      debounce_ticks_q <= DebounceTicksRst;
      long_ticks_q     <= LongTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ACTIVE_LEVEL:   active_level_q   <= cfg_data_i[0];
        REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i[DebW-1:0];
        REG_LONG_TICKS:     long_ticks_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ev_d    = EV_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (pressed) phase_d = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (pressed) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= {{(CntW - DebW){1'b0}}, debounce_ticks_q}) phase_d = PH_HELD;
        end else begin
          // bounce aborts confirmation
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      end
      PH_HELD: begin
        if (pressed) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= long_ticks_q) begin
            phase_d = PH_LONG;
            ev_d    = EV_LONG;
          end
        end else if (cnt_q < long_ticks_q) begin
          phase_d = PH_SHORT;
        end else begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      end
      PH_SHORT: begin
        if (!pressed) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
          ev_d    = EV_SHORT;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) ev_q <= ev_d;
  end

  a_idle_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_IDLE) |=> (m_axis_tdata_o[1:0] == EV_NONE))
    else $error("event reported from idle phase");

  a_long_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_LONG) |=> (m_axis_tdata_o[1:0] == EV_NONE))
    else $error("event reported while awaiting release after long press");

  a_short_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_SHORT && !pressed)
      |=> (phase_q == PH_IDLE && cnt_q == '0 && m_axis_tdata_o[1:0] == EV_SHORT))
    else $error("short press release not reported");

  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (cnt_q >= $past(cnt_q) || cnt_q == '0))
    else $error("press counter moved backwards");

endmodule

`default_nettype wire

// File: tb/key_short_long_press_classifier_test.sv
// self-checking bench for key_short_long_press_classifier: pin samples in, press events out
// depends on kslpc_pkg and the classifier rtl; predicts every event word and compares in order
`default_nettype none

module key_short_long_press_classifier_test;
  import kslpc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;  // index with no register behind it

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  key_short_long_press_classifier u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // classifier state as the bench sees it
  logic            key_active   = ActiveLevelRst;
  logic [DebW-1:0] key_debounce = DebounceTicksRst;
  logic [CntW-1:0] key_long     = LongTicksRst;
  phase_e          key_phase    = PH_IDLE;
  logic [CntW-1:0] hold_count   = '0;

  logic   sample_q[$];   // pin levels waiting to be sent
  event_e event_q[$];    // press events still to come out
  int     mismatches = 0;

  function automatic event_e classify_sample(input logic pin);
    logic   pressed;
    event_e ev;
    pressed = (pin == key_active);
    ev = EV_NONE;
    case (key_phase)
      PH_IDLE: begin
        if (pressed) key_phase = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (pressed) begin
          if (hold_count != '1) hold_count++;
          if (hold_count >= key_debounce) key_phase = PH_HELD;
        end else begin
          key_phase = PH_IDLE;
          hold_count = '0;
        end
      end
      PH_HELD: begin
        if (pressed) begin
          if (hold_count != '1) hold_count++;
          if (hold_count >= key_long) begin
            key_phase = PH_LONG;
            ev = EV_LONG;
          end
        end else if (hold_count < key_long) begin
          key_phase = PH_SHORT;
        end else begin
          key_phase = PH_IDLE;
          hold_count = '0;
        end
      end
      PH_SHORT: begin
        if (!pressed) begin
          key_phase = PH_IDLE;
          hold_count = '0;
          ev = EV_SHORT;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          key_phase = PH_IDLE;
          hold_count = '0;
        end
      end
      default: begin
        key_phase = PH_IDLE;
        hold_count = '0;
      end
    endcase
    return ev;
  endfunction

  // sender: bursts of words with random gaps, fed from sample_q
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) event_q.push_back(classify_sample(s_tdata[0]));
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {7'b0, sample_q.pop_front()};
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  // event checker
  logic [7:0] want_word;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (event_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected event word %h", m_tdata);
        mismatches++;
      end else begin
        want_word = {6'b0, event_q.pop_front()};
        if (m_tdata !== want_word) begin
          if (mismatches < 10) $display("press_event mismatch: expected %h got %h",
                                        want_word, m_tdata);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_ACTIVE_LEVEL:   key_active = val[0];
      REG_DEBOUNCE_TICKS: key_debounce = val[DebW-1:0];
      REG_LONG_TICKS:     key_long = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_keys(input logic act, input logic [DebW-1:0] deb,
                          input logic [CntW-1:0] lng);
    write_reg(REG_ACTIVE_LEVEL, {15'b0, act});
    write_reg(REG_DEBOUNCE_TICKS, {8'b0, deb});
    write_reg(REG_LONG_TICKS, lng);
  endtask

  // hold off until every word is sent and every event has come back
  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || event_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_run(input logic pressed, input int n);
    repeat (n) sample_q.push_back(pressed ? key_active : !key_active);
  endtask

  // mostly well-formed presses with lengths near the thresholds, some noise
  task automatic press_mix(input int n_items);
    int pushed;
    int len;
    int rel;
    int hi;
    pushed = 0;
    while (pushed < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 8);
          repeat (len) sample_q.push_back(1'($urandom_range(0, 1)));
          rel = 0;
        end
        1, 2: begin
          len = int'(key_debounce) + $urandom_range(0, 4) - 1;
          if (len < 1) len = 1;
          rel = $urandom_range(1, 4);
        end
        3, 4, 5, 6: begin
          hi = int'(key_long);
          if (hi > int'(key_debounce) + 60) hi = int'(key_debounce) + 60;
          if (hi < int'(key_debounce) + 1) hi = int'(key_debounce) + 1;
          len = $urandom_range(int'(key_debounce) + 1, hi);
          rel = $urandom_range(1, 4);
        end
        default: begin
          if (key_long > 4000) len = $urandom_range(1, 20);
          else len = int'(key_long) + $urandom_range(0, 4) - 1;
          if (len < 1) len = 1;
          rel = $urandom_range(1, 4);
        end
      endcase
      if (rel != 0) begin
        push_run(1'b1, len);
        push_run(1'b0, rel);
      end
      pushed += len + rel;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: a bounce then a short press
    push_run(1'b1, 2); push_run(1'b0, 1);
    push_run(1'b1, 5); push_run(1'b0, 2);
    drain();

    // long press, held past the report
    set_keys(1'b1, 8'd1, 16'd4);
    push_run(1'b1, 6); push_run(1'b0, 2);
    drain();

    // long threshold lowered mid-press: release after it gives no event
    write_reg(REG_LONG_TICKS, 16'd10);
    push_run(1'b1, 4);
    drain();
    write_reg(REG_LONG_TICKS, 16'd2);
    push_run(1'b0, 2);
    drain();

    // zero thresholds met on the first counted tick
    set_keys(1'b0, 8'd0, 16'd0);
    push_run(1'b1, 3); push_run(1'b0, 2);
    drain();
    write_reg(RegSpare, 16'hA5C3);
    push_run(1'b1, 2); push_run(1'b0, 1);
    drain();

    set_keys(1'b0, DebounceTicksRst, LongTicksRst);
    press_mix(350);
    drain();
    set_keys(1'b1, 8'd1, 16'd4);
    press_mix(200);
    drain();
    set_keys(1'b0, 8'd2, 16'd10);
    press_mix(250);
    drain();
    set_keys(1'b1, 8'd0, 16'd2);
    press_mix(150);
    drain();
    set_keys(1'b0, 8'd255, 16'd258);
    press_mix(450);
    drain();

    // long press held well past the report
    set_keys(1'b1, 8'd5, 16'd40);
    push_run(1'b1, 45); push_run(1'b0, 2);
    press_mix(60);
    drain();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
